/* design/crrs_pkg.sv */
// ----------------------------------------------------------------------------
// crrs_pkg: shared definitions for circular row run statistics
// Field widths, parameter defaults and the divider status type.
// ----------------------------------------------------------------------------
`default_nettype none

package crrs_pkg;

  localparam int unsigned MAX_ROW_LENGTH_DEF = 1024;

  localparam int unsigned SAMPLE_W         = 16;
  localparam int unsigned NUM_FINGERS_W    = 10;
  localparam int unsigned BURN_WIDTH_W     = 11;
  localparam int unsigned FINGER_SPACING_W = 11;

  // status of the shared divider as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* design/circular_row_run_statistics.sv */
// ----------------------------------------------------------------------------
// circular_row_run_statistics: finger statistics over one circular grid row
// Top level: threshold register, row accumulator, divider sequencer and
// result register.
// ----------------------------------------------------------------------------
// Samples of a row transfer one per cycle while the block is out of reset and
// idle. When the row's last sample transfers, the block stops taking samples
// while one shared restoring divider computes burned/fingers and then
// length/fingers, one quotient bit per cycle (CNT_W = 11 for the default row
// length of 1024). A row with no fingers skips the divider, and the block also
// waits while an earlier result is still held in the output register. The
// result sits in an output register, so the next row may start while it waits
// to be taken. The threshold register should be written only while no row is
// in progress.
`default_nettype none

module circular_row_run_statistics #(
  parameter int unsigned MAX_ROW_LENGTH = crrs_pkg::MAX_ROW_LENGTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic signed [crrs_pkg::SAMPLE_W-1:0]     cfg_burn_threshold,
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic signed [crrs_pkg::SAMPLE_W-1:0]     in_sample_value,
  input  wire logic                                     in_last_in_row,
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic [crrs_pkg::NUM_FINGERS_W-1:0]            out_num_fingers,
  output logic [crrs_pkg::BURN_WIDTH_W-1:0]             out_burn_width,
  output logic [crrs_pkg::FINGER_SPACING_W-1:0]         out_finger_spacing,
  output logic                                          out_no_fingers,
  output logic                                          out_odd_count
);

  localparam int unsigned CNT_W = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned EXT_W = (CNT_W > 11) ? CNT_W : 11;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV_W = 4'b0010,
    S_DIV_S = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [crrs_pkg::SAMPLE_W-1:0] thr_r;

  logic             in_xfer;
  logic [CNT_W-1:0] fin_trans, fin_burned, fin_samples;
  logic [CNT_W-2:0] fin_fingers;

  logic [CNT_W-2:0] fingers_r;
  logic [CNT_W-1:0] burned_r;
  logic [CNT_W-1:0] samples_r;
  logic [CNT_W-1:0] width_r;
  logic [CNT_W-1:0] spacing_r;
  logic             start_r;

  logic [CNT_W-1:0]    div_quo;
  logic [CNT_W-1:0]    div_dividend;
  crrs_pkg::div_stat_t div_stat;

  logic             out_free;
  logic             out_valid_r;
  logic [EXT_W-1:0] fing_ext, width_ext, spacing_ext;

  // configuration
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_burn_threshold;
    end
  end

  assign in_stall = (state_r != S_IDLE) || !rst_n;
  assign in_xfer  = in_valid && !in_stall;

  crrs_row_acc #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .CNT_W          (CNT_W)
  ) u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_xfer),
    .sample      (in_sample_value),
    .last        (in_last_in_row),
    .threshold   (thr_r),
    .fin_trans   (fin_trans),
    .fin_burned  (fin_burned),
    .fin_samples (fin_samples)
  );

  assign fin_fingers  = fin_trans[CNT_W-1:1];
  assign div_dividend = (state_r == S_DIV_W) ? burned_r : samples_r;

  crrs_div #(
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (div_dividend),
    .divisor  (fingers_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_last_in_row) begin
          state_nxt = (fin_fingers == '0) ? S_OUT : S_DIV_W;
        end
      end
      S_DIV_W: begin
        if (div_stat.done) begin
          state_nxt = S_DIV_S;
        end
      end
      S_DIV_S: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= ((state_r == S_IDLE) && in_xfer && in_last_in_row &&
                  (fin_fingers != '0)) ||
                 ((state_r == S_DIV_W) && div_stat.done);
    end
  end

  // row totals and quotients
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_xfer && in_last_in_row) begin
      fingers_r <= fin_fingers;
      burned_r  <= fin_burned;
      samples_r <= fin_samples;
      width_r   <= '0;
      spacing_r <= '0;
    end else if (div_stat.done) begin
      if (state_r == S_DIV_W) begin
        width_r <= div_quo;
      end else begin
        spacing_r <= div_quo;
      end
    end
  end

  // result register
  assign fing_ext    = EXT_W'(fingers_r);
  assign width_ext   = EXT_W'(width_r);
  assign spacing_ext = EXT_W'(spacing_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_num_fingers    <= fing_ext[crrs_pkg::NUM_FINGERS_W-1:0];
      out_burn_width     <= width_ext[crrs_pkg::BURN_WIDTH_W-1:0];
      out_finger_spacing <= spacing_ext[crrs_pkg::FINGER_SPACING_W-1:0];
      out_no_fingers     <= (fingers_r == '0);
      out_odd_count      <= fingers_r[0];
    end
  end

  assign out_valid = out_valid_r;

  // checks
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV_W || state_r == S_DIV_S))
    else $error("divider finished outside a division state");

  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_rise_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised without passing the output state");

  a_zero_fingers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_no_fingers) |->
      (out_burn_width == '0 && out_finger_spacing == '0 && !out_odd_count))
    else $error("no-finger result carries nonzero width or spacing");

endmodule

`default_nettype wire

/* design/crrs_row_acc.sv */
// ----------------------------------------------------------------------------
// crrs_row_acc: per-row class tracking and saturating counters
// Classes each sample against the threshold, counts transitions, burned
// samples and samples, and presents the end-of-row totals including the
// wrap-around transition. Row state clears when the last sample transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module crrs_row_acc #(
  parameter int unsigned MAX_ROW_LENGTH = crrs_pkg::MAX_ROW_LENGTH_DEF,
  parameter int unsigned CNT_W          = $clog2(MAX_ROW_LENGTH + 1)
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               accept,
  input  wire logic signed [crrs_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                               last,
  input  wire logic signed [crrs_pkg::SAMPLE_W-1:0] threshold,
  output logic [CNT_W-1:0]                        fin_trans,
  output logic [CNT_W-1:0]                        fin_burned,
  output logic [CNT_W-1:0]                        fin_samples
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ROW_LENGTH);

  logic             first_r, first_nxt;
  logic             prev_r, prev_nxt;
  logic [CNT_W-1:0] trans_r, trans_nxt;
  logic [CNT_W-1:0] burned_r, burned_nxt;
  logic [CNT_W-1:0] samples_r, samples_nxt;

  logic             cls;
  logic             row_start;
  logic [CNT_W-1:0] trans_step;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < CNT_MAX) ? v + CNT_W'(1) : v;
  endfunction

  always_comb begin
    cls        = (sample < threshold);
    row_start  = (samples_r == '0);
    first_nxt  = row_start ? cls : first_r;
    prev_nxt   = cls;
    trans_step = (!row_start && (cls != prev_r)) ? sat_inc(trans_r) : trans_r;
    trans_nxt  = trans_step;
    burned_nxt = cls ? sat_inc(burned_r) : burned_r;
    samples_nxt = sat_inc(samples_r);
    // circular row: closing edge between last and first sample
    fin_trans   = (cls != first_nxt) ? sat_inc(trans_step) : trans_step;
    fin_burned  = burned_nxt;
    fin_samples = samples_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= 1'b0;
      prev_r    <= 1'b0;
      trans_r   <= '0;
      burned_r  <= '0;
      samples_r <= '0;
    end else if (accept) begin
      if (last) begin
        first_r   <= 1'b0;
        prev_r    <= 1'b0;
        trans_r   <= '0;
        burned_r  <= '0;
        samples_r <= '0;
      end else begin
        first_r   <= first_nxt;
        prev_r    <= prev_nxt;
        trans_r   <= trans_nxt;
        burned_r  <= burned_nxt;
        samples_r <= samples_nxt;
      end
    end
  end

endmodule

`default_nettype wire

/* design/crrs_div.sv */
// ----------------------------------------------------------------------------
// crrs_div: shared restoring divider
// One quotient bit per cycle, CNT_W quotient bits per division; done pulses once.
// ----------------------------------------------------------------------------
`default_nettype none

module crrs_div #(
  parameter int unsigned CNT_W = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] dividend,
  input  wire logic [CNT_W-2:0] divisor,
  output logic [CNT_W-1:0]      quotient,
  output crrs_pkg::div_stat_t   stat
);

  localparam int unsigned STEP_W = (CNT_W > 2) ? $clog2(CNT_W) : 1;

  logic [CNT_W-2:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W-1:0]  shifted;
  logic [CNT_W-1:0]  dsr_ext;
  logic [CNT_W-1:0]  diff;
  logic              ge;

  always_comb begin
    shifted = {rem_r, quo_r[CNT_W-1]};
    dsr_ext = {1'b0, divisor};
    diff    = shifted - dsr_ext;
    ge      = (shifted >= dsr_ext);
    rem_nxt = ge ? diff[CNT_W-2:0] : shifted[CNT_W-2:0];
    quo_nxt = {quo_r[CNT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(CNT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

/* sim/crrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crrs_checker: row statistics scoreboard
// Watches the threshold, sample and result channels. It keeps its own row
// accumulator and threshold, builds the expected finger statistics when a
// row's last sample transfers, and compares each result transfer with the
// oldest pending row.
// ----------------------------------------------------------------------------
module crrs_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_valid,
  input  wire logic                                   cfg_ready,
  input  wire logic signed [crrs_pkg::SAMPLE_W-1:0]   cfg_burn_threshold,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_stall,
  input  wire logic signed [crrs_pkg::SAMPLE_W-1:0]   in_sample_value,
  input  wire logic                                   in_last_in_row,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_stall,
  input  wire logic [crrs_pkg::NUM_FINGERS_W-1:0]     out_num_fingers,
  input  wire logic [crrs_pkg::BURN_WIDTH_W-1:0]      out_burn_width,
  input  wire logic [crrs_pkg::FINGER_SPACING_W-1:0]  out_finger_spacing,
  input  wire logic                                   out_no_fingers,
  input  wire logic                                   out_odd_count,
  output int                                          fail_count,
  output int                                          rows_pending
);

  localparam int unsigned ROW_CAP = crrs_pkg::MAX_ROW_LENGTH_DEF;

  typedef struct packed {
    logic [crrs_pkg::NUM_FINGERS_W-1:0]    fingers;
    logic [crrs_pkg::BURN_WIDTH_W-1:0]     width;
    logic [crrs_pkg::FINGER_SPACING_W-1:0] spacing;
    logic                                  none;
    logic                                  odd;
  } row_result_t;

  row_result_t pending_rows[$];
  row_result_t row_exp;

  logic signed [crrs_pkg::SAMPLE_W-1:0] threshold;
  logic        first_burned;
  logic        prev_burned;
  logic        burned;
  int unsigned edge_count;
  int unsigned burned_count;
  int unsigned row_len;
  int unsigned fingers;

  function automatic int unsigned sat_inc(input int unsigned v);
    return (v < ROW_CAP) ? v + 1 : v;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      threshold    = '0;
      first_burned = 1'b0;
      prev_burned  = 1'b0;
      edge_count   = 0;
      burned_count = 0;
      row_len      = 0;
      fail_count   = 0;
      pending_rows.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        threshold = cfg_burn_threshold;

      if (out_valid && !out_stall) begin
        if (pending_rows.size() == 0) begin
          fail_count++;
          $display("%0t: result transfer with no row pending: expected none, actual %0d/%0d/%0d/%0b/%0b",
                   $time, out_num_fingers, out_burn_width, out_finger_spacing,
                   out_no_fingers, out_odd_count);
        end else begin
          row_exp = pending_rows.pop_front();
          check_field("num_fingers", row_exp.fingers, out_num_fingers);
          check_field("burn_width", row_exp.width, out_burn_width);
          check_field("finger_spacing", row_exp.spacing, out_finger_spacing);
          check_field("no_fingers", row_exp.none, out_no_fingers);
          check_field("odd_count", row_exp.odd, out_odd_count);
        end
      end

      if (in_valid && !in_stall) begin
        burned = (in_sample_value < threshold);
        if (row_len == 0) begin
          first_burned = burned;
          prev_burned  = burned;
        end else if (burned != prev_burned) begin
          edge_count  = sat_inc(edge_count);
          prev_burned = burned;
        end
        if (burned)
          burned_count = sat_inc(burned_count);
        row_len = sat_inc(row_len);

        if (in_last_in_row) begin
          // the row wraps around: last sample neighbors the first
          if (prev_burned != first_burned)
            edge_count = sat_inc(edge_count);
          fingers = edge_count / 2;
          row_exp.fingers = fingers[crrs_pkg::NUM_FINGERS_W-1:0];
          row_exp.none    = (fingers == 0);
          row_exp.odd     = fingers[0];
          if (fingers != 0) begin
            row_exp.width   = 11'(burned_count / fingers);
            row_exp.spacing = 11'(row_len / fingers);
          end else begin
            row_exp.width   = '0;
            row_exp.spacing = '0;
          end
          pending_rows.insert(pending_rows.size(), row_exp);
          first_burned = 1'b0;
          prev_burned  = 1'b0;
          edge_count   = 0;
          burned_count = 0;
          row_len      = 0;
        end
      end
    end
    rows_pending = pending_rows.size();
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for circular_row_run_statistics
// Drives threshold writes and rows of samples, with directed corner rows,
// a saturating long row and random rows under several idle and stall mixes,
// including a long output hold-off. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 80;
  localparam int ALT_SPAN      = 1032;
  localparam int LONG_ROW_LEN  = 1100;
  localparam int HOLD_CYCLES   = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                  cfg_valid = 1'b0;
  logic                                  cfg_ready;
  logic signed [crrs_pkg::SAMPLE_W-1:0]  cfg_burn_threshold = '0;
  logic                                  in_valid = 1'b0;
  logic                                  in_stall;
  logic signed [crrs_pkg::SAMPLE_W-1:0]  in_sample_value = '0;
  logic                                  in_last_in_row = 1'b0;
  logic                                  out_valid;
  logic                                  out_stall = 1'b0;
  logic [crrs_pkg::NUM_FINGERS_W-1:0]    out_num_fingers;
  logic [crrs_pkg::BURN_WIDTH_W-1:0]     out_burn_width;
  logic [crrs_pkg::FINGER_SPACING_W-1:0] out_finger_spacing;
  logic                                  out_no_fingers;
  logic                                  out_odd_count;

  int fail_count;
  int rows_pending;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          hold_cycles = 0;
  int          cur_threshold = 0;

  logic signed [crrs_pkg::SAMPLE_W-1:0] row_buf[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_row_run_statistics u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_burn_threshold (cfg_burn_threshold),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_value    (in_sample_value),
    .in_last_in_row     (in_last_in_row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_num_fingers    (out_num_fingers),
    .out_burn_width     (out_burn_width),
    .out_finger_spacing (out_finger_spacing),
    .out_no_fingers     (out_no_fingers),
    .out_odd_count      (out_odd_count)
  );

  crrs_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_burn_threshold (cfg_burn_threshold),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_value    (in_sample_value),
    .in_last_in_row     (in_last_in_row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_num_fingers    (out_num_fingers),
    .out_burn_width     (out_burn_width),
    .out_finger_spacing (out_finger_spacing),
    .out_no_fingers     (out_no_fingers),
    .out_odd_count      (out_odd_count),
    .fail_count         (fail_count),
    .rows_pending       (rows_pending)
  );

  // registered transfer flags, read by the stimulus at the falling edge
  always @(posedge clk) begin
    in_taken  <= in_valid && !in_stall;
    cfg_taken <= cfg_valid && cfg_ready;
  end

  // result side: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // mix of fully random levels and levels close to the threshold
  function automatic logic signed [crrs_pkg::SAMPLE_W-1:0] pick_sample(input int th);
    logic [31:0] bits;
    int          v;
    bits = $urandom;
    if (bits[31])
      return bits[15:0];
    v = th + int'(bits[22:16]) - 64;
    if (v > 32767)
      v = 32767;
    else if (v < -32768)
      v = -32768;
    return v[15:0];
  endfunction

  task automatic send_sample(input logic signed [crrs_pkg::SAMPLE_W-1:0] value,
                             input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= value;
    in_last_in_row  <= last;
    @(negedge clk);
    while (in_taken !== 1'b1)
      @(negedge clk);
  endtask

  task automatic send_buffered_row();
    foreach (row_buf[i])
      send_sample(row_buf[i], i == row_buf.size() - 1);
  endtask

  // drop valid, wait for every pending row, then let the divider settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (rows_pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(input logic signed [crrs_pkg::SAMPLE_W-1:0] value);
    cfg_valid          <= 1'b1;
    cfg_burn_threshold <= value;
    cur_threshold = value;
    @(negedge clk);
    while (cfg_taken !== 1'b1)
      @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int row_len;
    int phase_items;
    int v;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // threshold still at its reset value of zero
    row_buf = '{-32768};
    send_buffered_row();
    row_buf = '{32767};
    send_buffered_row();
    row_buf = '{-1, 0, -1, 0};
    send_buffered_row();
    row_buf = '{-1, 0};
    send_buffered_row();
    row_buf = '{0, 0, 0};
    send_buffered_row();
    row_buf = '{-1, -1, 5, -1};
    send_buffered_row();

    // lowest threshold: nothing can be burned
    wait_drained();
    write_threshold(-32768);
    row_buf = '{-32768, 32767, -32768, 0};
    send_buffered_row();

    // highest threshold: everything but the top level is burned
    wait_drained();
    write_threshold(32767);
    row_buf = '{32767, 32766, 32767, -32768};
    send_buffered_row();

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0: write_threshold(16'(int'($urandom_range(32767)) - 16384));
        1: write_threshold(32767);
        2: write_threshold(16'($urandom));
        default: write_threshold(16'(int'($urandom_range(511)) - 256));
      endcase
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 61; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 61; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase

      if (p == 0) begin
        // alternating classes saturate the edge count, the length
        // saturates the sample count
        for (int k = 0; k < LONG_ROW_LEN; k++) begin
          if (k < ALT_SPAN && k % 2 == 0)
            v = cur_threshold + int'($urandom_range(32767 - cur_threshold));
          else
            v = cur_threshold - 1 - int'($urandom_range(cur_threshold + 32767));
          send_sample(v[15:0], k == LONG_ROW_LEN - 1);
        end
        // hold off results while rows keep coming so the input backs up
        @(posedge clk);
        hold_cycles = HOLD_CYCLES;
        @(negedge clk);
      end

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        row_len = ($urandom_range(9) == 0) ? $urandom_range(80, 17) : $urandom_range(16, 1);
        for (int k = 0; k < row_len; k++)
          send_sample(pick_sample(cur_threshold), k == row_len - 1);
        phase_items += row_len;
      end
    end

    wait_drained();
    if (fail_count == 0 && rows_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("%0t: run did not complete", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
